// ===== rtl/enrs_pkg.sv =====
`default_nettype none

package enrs_pkg;

    // input word kinds
    localparam logic [2:0] KIND_TICK        = 3'd0;
    localparam logic [2:0] KIND_COMMAND     = 3'd1;
    localparam logic [2:0] KIND_LINK_UP     = 3'd2;
    localparam logic [2:0] KIND_LINK_DOWN   = 3'd3;
    localparam logic [2:0] KIND_BIRTH_SENT  = 3'd4;
    localparam logic [2:0] KIND_DATA_SENT   = 3'd5;
    localparam logic [2:0] KIND_DEATH_REQ   = 3'd6;

    // report topics
    localparam logic [1:0] TOPIC_NONE  = 2'd0;
    localparam logic [1:0] TOPIC_BIRTH = 2'd1;
    localparam logic [1:0] TOPIC_DATA  = 2'd2;
    localparam logic [1:0] TOPIC_DEATH = 2'd3;

    // birth/death sequence wraps to zero once it is above this value
    localparam logic [7:0] BD_SEQ_TOP = 8'd254;

    localparam logic [31:0] SCAN_PERIOD_RESET = 32'd1000;

    typedef enum logic [3:0] {
        ST_NOT_DUE    = 4'd0,
        ST_BIRTH      = 4'd1,
        ST_HIST_BIRTH = 4'd2,
        ST_BIRTH_FAIL = 4'd3,
        ST_UNCHANGED  = 4'd4,
        ST_DATA       = 4'd5,
        ST_HIST_DATA  = 4'd6,
        ST_DATA_FAIL  = 4'd7,
        ST_DEATH      = 4'd8,
        ST_DEATH_FAIL = 4'd9,
        ST_CMD_OK     = 4'd10,
        ST_CMD_FAIL   = 4'd11,
        ST_DONE       = 4'd12
    } status_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] now;
        logic        tags_changed;
        logic        build_ok;
        logic        rebirth_request;
    } event_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  topic;
        logic [7:0]  seq_number;
        logic [7:0]  bd_seq_number;
        logic [63:0] report_time;
    } report_t;

endpackage

`default_nettype wire

// ===== rtl/edge_node_report_sequencer.sv =====
`default_nettype none

// channel | direction | handshake           | word
// --------+-----------+---------------------+---------------------------
// in      | input     | in_valid / in_stall | enrs_pkg::event_t
// out     | output    | out_valid/out_stall | enrs_pkg::report_t
// cfg     | input     | cfg_valid/cfg_ready | scan_period, 32 bits
//
// one event word per cycle sustained while out_stall is low; an event
// goes through the input register, then the result register, before its
// result is valid
// the decision and all state updates happen in one pass between the two
// registers, so each event sees the state left by the one before it
// rst_n clears the node state and scan_period returns to 1000
// an out_stall holds the result register and backs up into in_stall

module edge_node_report_sequencer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire enrs_pkg::event_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output enrs_pkg::report_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [31:0]       cfg_data
);

    // pipeline registers and the next result word
    logic               s1_valid_reg;
    enrs_pkg::event_t   s1_item_reg;
    logic               out_valid_reg;
    enrs_pkg::report_t  out_reg;
    enrs_pkg::report_t  report_next;

    // node state
    logic [31:0] scan_period_reg;
    logic [63:0] last_scan_time_reg, last_scan_time_next;
    logic        force_scan_reg, force_scan_next;
    logic        changed_reg, changed_next;
    logic [7:0]  msg_seq_reg, msg_seq_next;
    logic [7:0]  bd_seq_reg, bd_seq_next;
    logic        birth_done_reg, birth_done_next;
    logic        link_up_reg, link_up_next;
    logic        rebirth_reg, rebirth_next;

    logic        out_load;
    logic        s1_fire;
    logic [63:0] elapsed;
    logic        scan_due;

    // handshake control
    assign out_load  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_load;
    assign in_stall  = s1_valid_reg && !out_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = !s1_valid_reg;

    // scan due test
    assign elapsed  = s1_item_reg.now - last_scan_time_reg;
    assign scan_due = force_scan_reg || (last_scan_time_reg == 64'd0)
                      || (elapsed >= {32'd0, scan_period_reg});

    // event decode and state update
    always_comb
    begin
        last_scan_time_next = last_scan_time_reg;
        force_scan_next     = force_scan_reg;
        changed_next        = changed_reg;
        msg_seq_next        = msg_seq_reg;
        bd_seq_next         = bd_seq_reg;
        birth_done_next     = birth_done_reg;
        link_up_next        = link_up_reg;
        rebirth_next        = rebirth_reg;
        report_next.status  = enrs_pkg::ST_DONE;
        report_next.topic   = enrs_pkg::TOPIC_NONE;

        case (s1_item_reg.kind)
            enrs_pkg::KIND_TICK:
            begin
                if (!scan_due)
                begin
                    report_next.status = enrs_pkg::ST_NOT_DUE;
                end
                else
                begin
                    force_scan_next     = 1'b0;
                    changed_next        = s1_item_reg.tags_changed;
                    last_scan_time_next = s1_item_reg.now;
                    if (rebirth_reg || !birth_done_reg)
                    begin
                        rebirth_next = 1'b0;
                        msg_seq_next = 8'd0;
                        if (s1_item_reg.build_ok)
                        begin
                            report_next.status = link_up_reg ? enrs_pkg::ST_BIRTH
                                                             : enrs_pkg::ST_HIST_BIRTH;
                            report_next.topic  = enrs_pkg::TOPIC_BIRTH;
                        end
                        else
                        begin
                            report_next.status = enrs_pkg::ST_BIRTH_FAIL;
                        end
                    end
                    else if (!s1_item_reg.tags_changed)
                    begin
                        report_next.status = enrs_pkg::ST_UNCHANGED;
                    end
                    else if (s1_item_reg.build_ok)
                    begin
                        report_next.status = link_up_reg ? enrs_pkg::ST_DATA
                                                         : enrs_pkg::ST_HIST_DATA;
                        report_next.topic  = enrs_pkg::TOPIC_DATA;
                    end
                    else
                    begin
                        report_next.status = enrs_pkg::ST_DATA_FAIL;
                    end
                end
            end
            enrs_pkg::KIND_COMMAND:
            begin
                force_scan_next = 1'b1;
                if (s1_item_reg.build_ok)
                begin
                    if (s1_item_reg.rebirth_request)
                    begin
                        rebirth_next = 1'b1;
                    end
                    report_next.status = enrs_pkg::ST_CMD_OK;
                end
                else
                begin
                    report_next.status = enrs_pkg::ST_CMD_FAIL;
                end
            end
            enrs_pkg::KIND_LINK_UP:
            begin
                link_up_next = 1'b1;
                if (birth_done_reg)
                begin
                    rebirth_next = 1'b1;
                end
            end
            enrs_pkg::KIND_LINK_DOWN:
            begin
                link_up_next = 1'b0;
            end
            enrs_pkg::KIND_BIRTH_SENT:
            begin
                birth_done_next = 1'b1;
                msg_seq_next    = msg_seq_reg + 8'd1;
            end
            enrs_pkg::KIND_DATA_SENT:
            begin
                msg_seq_next = msg_seq_reg + 8'd1;
            end
            enrs_pkg::KIND_DEATH_REQ:
            begin
                if (birth_done_reg)
                begin
                    bd_seq_next = (bd_seq_reg > enrs_pkg::BD_SEQ_TOP) ? 8'd0
                                                                      : bd_seq_reg + 8'd1;
                end
                if (s1_item_reg.build_ok)
                begin
                    report_next.status = enrs_pkg::ST_DEATH;
                    report_next.topic  = enrs_pkg::TOPIC_DEATH;
                end
                else
                begin
                    report_next.status = enrs_pkg::ST_DEATH_FAIL;
                end
            end
            default:
            begin
                report_next.status = enrs_pkg::ST_DONE;
            end
        endcase

        report_next.seq_number    = msg_seq_next;
        report_next.bd_seq_number = bd_seq_next;
        report_next.report_time   = (report_next.topic != enrs_pkg::TOPIC_NONE)
                                    ? s1_item_reg.now : 64'd0;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg <= in_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_reg <= report_next;
        end
    end

    // node state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg    <= enrs_pkg::SCAN_PERIOD_RESET;
            last_scan_time_reg <= 64'd0;
            force_scan_reg     <= 1'b0;
            changed_reg        <= 1'b0;
            msg_seq_reg        <= 8'd0;
            bd_seq_reg         <= 8'd0;
            birth_done_reg     <= 1'b0;
            link_up_reg        <= 1'b0;
            rebirth_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                scan_period_reg <= cfg_data;
            end
            if (s1_fire)
            begin
                last_scan_time_reg <= last_scan_time_next;
                force_scan_reg     <= force_scan_next;
                changed_reg        <= changed_next;
                msg_seq_reg        <= msg_seq_next;
                bd_seq_reg         <= bd_seq_next;
                birth_done_reg     <= birth_done_next;
                link_up_reg        <= link_up_next;
                rebirth_reg        <= rebirth_next;
            end
        end
    end

    // checks on the decision logic and the pipeline
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline can move");

    a_death_topic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.topic == enrs_pkg::TOPIC_DEATH)
                           == (out_reg.status == enrs_pkg::ST_DEATH)))
        else $error("death topic and death status disagree");

    a_birth_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.topic == enrs_pkg::TOPIC_BIRTH)
        |-> (out_reg.seq_number == 8'd0))
        else $error("birth report without a zeroed sequence number");

    a_no_report_no_time: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.topic == enrs_pkg::TOPIC_NONE)
        |-> (out_reg.report_time == 64'd0))
        else $error("report time set with no report");

    a_seq_follows_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (out_reg.seq_number == msg_seq_reg
                     && out_reg.bd_seq_number == bd_seq_reg))
        else $error("result counters differ from the node state");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // kind code with no meaning to the node
    localparam logic [2:0]        KIND_UNUSED = 3'd7;
    localparam enrs_pkg::report_t NO_CHECK    = '0;
    localparam int                PHASES      = 6;
    localparam int                PHASE_WORDS = 305;
    localparam int                BURST_WORDS = 260;
    localparam int                HOLD_CYCLES = 300;

    // one directed word: event, whether the report is typed in, the report
    typedef struct packed {
        enrs_pkg::event_t  ev;
        logic              typed;
        enrs_pkg::report_t want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    enrs_pkg::event_t  in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    enrs_pkg::report_t out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [31:0]       cfg_data = '0;

    // node state as predicted by the testbench
    logic [31:0] node_scan_period = enrs_pkg::SCAN_PERIOD_RESET;
    logic [63:0] node_last_scan = '0;
    logic        node_force_scan = 1'b0;
    logic        node_changed = 1'b0;
    logic [7:0]  node_msg_seq = '0;
    logic [7:0]  node_bd_seq = '0;
    logic        node_birth_done = 1'b0;
    logic        node_link_up = 1'b0;
    logic        node_rebirth = 1'b0;

    enrs_pkg::report_t expected_reports[$];
    stim_row_t         directed_rows[0:19];
    logic [63:0]       tick_time = 64'd10;
    int                tx_idle_pct = 31;
    int                rx_idle_pct = 79;
    int                mismatch_count = 0;
    int                hold_left = 0;
    bit                hold_request = 1'b0;
    bit                hold_taken = 1'b0;

    edge_node_report_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // next report of the node for one event, advancing the predicted state
    function automatic enrs_pkg::report_t predict_report(input enrs_pkg::event_t ev);
        enrs_pkg::report_t r;
        logic              due;
        r = '0;
        r.status = enrs_pkg::ST_DONE;
        r.topic = enrs_pkg::TOPIC_NONE;
        case (ev.kind)
            enrs_pkg::KIND_TICK:
            begin
                if (node_force_scan)
                begin
                    node_force_scan = 1'b0;
                    due = 1'b1;
                end
                else
                begin
                    due = (node_last_scan == 64'd0) ||
                          ((ev.now - node_last_scan) >= {32'd0, node_scan_period});
                end
                if (!due)
                begin
                    r.status = enrs_pkg::ST_NOT_DUE;
                end
                else
                begin
                    node_changed = ev.tags_changed;
                    node_last_scan = ev.now;
                    if (node_rebirth || !node_birth_done)
                    begin
                        node_rebirth = 1'b0;
                        node_msg_seq = 8'd0;
                        if (!ev.build_ok)
                            r.status = enrs_pkg::ST_BIRTH_FAIL;
                        else
                        begin
                            r.topic = enrs_pkg::TOPIC_BIRTH;
                            if (node_link_up)
                                r.status = enrs_pkg::ST_BIRTH;
                            else
                                r.status = enrs_pkg::ST_HIST_BIRTH;
                        end
                    end
                    else if (!node_changed)
                        r.status = enrs_pkg::ST_UNCHANGED;
                    else if (!ev.build_ok)
                        r.status = enrs_pkg::ST_DATA_FAIL;
                    else
                    begin
                        r.topic = enrs_pkg::TOPIC_DATA;
                        if (node_link_up)
                            r.status = enrs_pkg::ST_DATA;
                        else
                            r.status = enrs_pkg::ST_HIST_DATA;
                    end
                end
            end
            enrs_pkg::KIND_COMMAND:
            begin
                node_force_scan = 1'b1;
                if (ev.build_ok)
                begin
                    if (ev.rebirth_request)
                        node_rebirth = 1'b1;
                    r.status = enrs_pkg::ST_CMD_OK;
                end
                else
                    r.status = enrs_pkg::ST_CMD_FAIL;
            end
            enrs_pkg::KIND_LINK_UP:
            begin
                node_link_up = 1'b1;
                if (node_birth_done)
                    node_rebirth = 1'b1;
            end
            enrs_pkg::KIND_LINK_DOWN:
                node_link_up = 1'b0;
            enrs_pkg::KIND_BIRTH_SENT:
            begin
                node_birth_done = 1'b1;
                node_msg_seq = node_msg_seq + 8'd1;
            end
            enrs_pkg::KIND_DATA_SENT:
                node_msg_seq = node_msg_seq + 8'd1;
            enrs_pkg::KIND_DEATH_REQ:
            begin
                if (node_birth_done)
                    node_bd_seq = (node_bd_seq > enrs_pkg::BD_SEQ_TOP) ? 8'd0
                                                                       : node_bd_seq + 8'd1;
                if (ev.build_ok)
                begin
                    r.status = enrs_pkg::ST_DEATH;
                    r.topic = enrs_pkg::TOPIC_DEATH;
                end
                else
                    r.status = enrs_pkg::ST_DEATH_FAIL;
            end
            default:
                ;
        endcase
        r.seq_number = node_msg_seq;
        r.bd_seq_number = node_bd_seq;
        r.report_time = (r.topic != enrs_pkg::TOPIC_NONE) ? ev.now : 64'd0;
        return r;
    endfunction

    // random event; ticks mostly follow a running timeline, some steps near the period
    function automatic enrs_pkg::event_t random_event();
        enrs_pkg::event_t ev;
        logic [63:0]      step;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 40)
            ev.kind = enrs_pkg::KIND_TICK;
        else if (pick < 50)
            ev.kind = enrs_pkg::KIND_COMMAND;
        else if (pick < 57)
            ev.kind = enrs_pkg::KIND_LINK_UP;
        else if (pick < 64)
            ev.kind = enrs_pkg::KIND_LINK_DOWN;
        else if (pick < 76)
            ev.kind = enrs_pkg::KIND_BIRTH_SENT;
        else if (pick < 86)
            ev.kind = enrs_pkg::KIND_DATA_SENT;
        else if (pick < 96)
            ev.kind = enrs_pkg::KIND_DEATH_REQ;
        else
            ev.kind = KIND_UNUSED;
        ev.tags_changed = 1'($urandom_range(1));
        ev.build_ok = ($urandom_range(9) != 0);
        ev.rebirth_request = 1'($urandom_range(1));
        ev.now = {$urandom, $urandom};
        if (ev.kind == enrs_pkg::KIND_TICK)
        begin
            case ($urandom_range(19))
                0: ev.now = 64'd0;
                // arbitrary point, time may run backwards
                1: ;
                default:
                begin
                    case ($urandom_range(3))
                        0: step = 64'($urandom_range(3));
                        1: step = {32'd0, node_scan_period} + 64'($urandom_range(2)) - 64'd1;
                        2: step = 64'($urandom);
                        default: step = {30'd0, 2'($urandom_range(3)), $urandom};
                    endcase
                    tick_time = tick_time + step;
                    ev.now = tick_time;
                end
            endcase
        end
        return ev;
    endfunction

    // offer one word, optionally after idle cycles, and record its report
    task automatic send_event(input enrs_pkg::event_t ev, input logic typed,
                              input enrs_pkg::report_t want);
        enrs_pkg::report_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_report(ev);
        expected_reports.push_back(typed ? want : predicted);
    endtask

    // stop offering and let every outstanding report come back
    task automatic wait_for_reports();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_scan_period(input logic [31:0] period);
        cfg_valid <= 1'b1;
        cfg_data <= period;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        node_scan_period = period;
    endtask

    // report checker and receiver stall
    always @(posedge clk)
    begin : report_check
        enrs_pkg::report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: report with none expected, got %h", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, out_data.status);
                    mismatch_count++;
                end
                if (out_data.topic !== want.topic)
                begin
                    $display("%0t: topic expected %0d got %0d",
                             $time, want.topic, out_data.topic);
                    mismatch_count++;
                end
                if (out_data.seq_number !== want.seq_number)
                begin
                    $display("%0t: seq_number expected %0d got %0d",
                             $time, want.seq_number, out_data.seq_number);
                    mismatch_count++;
                end
                if (out_data.bd_seq_number !== want.bd_seq_number)
                begin
                    $display("%0t: bd_seq_number expected %0d got %0d",
                             $time, want.bd_seq_number, out_data.bd_seq_number);
                    mismatch_count++;
                end
                if (out_data.report_time !== want.report_time)
                begin
                    $display("%0t: report_time expected %h got %h",
                             $time, want.report_time, out_data.report_time);
                    mismatch_count++;
                end
            end
        end
        // one long hold, counted here once the stimulus asks for it
        if (hold_request && !hold_taken)
        begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    initial
    begin
        enrs_pkg::event_t ev;
        logic [2:0]       burst_kind;
        int               burst_left;
        // row layout: {kind, now, tags_changed, build_ok, rebirth_request}, typed, report
        directed_rows = '{
            // unused kind touches nothing
            {{KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1}, 1'b1,
             {enrs_pkg::ST_DONE, enrs_pkg::TOPIC_NONE, 8'd0, 8'd0, 64'd0}},
            // first scan at time zero, birth build fails
            {{enrs_pkg::KIND_TICK, 64'd0, 1'b1, 1'b0, 1'b0}, 1'b1,
             {enrs_pkg::ST_BIRTH_FAIL, enrs_pkg::TOPIC_NONE, 8'd0, 8'd0, 64'd0}},
            // scan at zero counts as never scanned, link down gives historical birth
            {{enrs_pkg::KIND_TICK, 64'd5, 1'b0, 1'b1, 1'b0}, 1'b1,
             {enrs_pkg::ST_HIST_BIRTH, enrs_pkg::TOPIC_BIRTH, 8'd0, 8'd0, 64'd5}},
            {{enrs_pkg::KIND_TICK, 64'd6, 1'b1, 1'b1, 1'b1}, 1'b0, NO_CHECK},
            // death before first birth keeps bd_seq
            {{enrs_pkg::KIND_DEATH_REQ, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0}, 1'b1,
             {enrs_pkg::ST_DEATH, enrs_pkg::TOPIC_DEATH, 8'd0, 8'd0,
              64'hFFFF_FFFF_FFFF_FFFF}},
            {{enrs_pkg::KIND_BIRTH_SENT, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 1'b1, 1'b1},
             1'b0, NO_CHECK},
            {{enrs_pkg::KIND_DATA_SENT, 64'h5A5A_A5A5_F0F0_0F0F, 1'b0, 1'b0, 1'b0},
             1'b0, NO_CHECK},
            {{enrs_pkg::KIND_LINK_UP, 64'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CHECK},
            // time going backwards wraps, rebirth after link up
            {{enrs_pkg::KIND_TICK, 64'd3, 1'b1, 1'b1, 1'b0}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_TICK, 64'd1003, 1'b1, 1'b1, 1'b0}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_TICK, 64'd2003, 1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
            // failed decode forces a scan, rebirth ignored
            {{enrs_pkg::KIND_COMMAND, 64'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_TICK, 64'd2004, 1'b1, 1'b0, 1'b0}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_COMMAND, 64'd0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_LINK_DOWN, 64'd0, 1'b1, 1'b1, 1'b1}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_TICK, 64'd2005, 1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_COMMAND, 64'd0, 1'b1, 1'b1, 1'b0}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_TICK, 64'd2006, 1'b1, 1'b1, 1'b0}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_DEATH_REQ, 64'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_CHECK},
            {{enrs_pkg::KIND_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1},
             1'b0, NO_CHECK}
        };
        burst_kind = enrs_pkg::KIND_DATA_SENT;
        burst_left = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words against the reset scan period
        foreach (directed_rows[i])
            send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
        wait_for_reports();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 2)
            begin
                tx_idle_pct = 31;
                rx_idle_pct = 79;
            end
            else if (phase < 4)
            begin
                tx_idle_pct = 79;
                rx_idle_pct = 31;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (phase)
                0: write_scan_period(32'd0);
                1: write_scan_period(32'hFFFF_FFFF);
                2: write_scan_period(32'd1);
                3: write_scan_period(32'($urandom_range(5000, 2)));
                4: write_scan_period(enrs_pkg::SCAN_PERIOD_RESET);
                default: write_scan_period($urandom);
            endcase
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // long runs of publishes wrap the sequence counters
                if (i == 20 && phase == 1)
                begin
                    burst_kind = enrs_pkg::KIND_DATA_SENT;
                    burst_left = BURST_WORDS;
                end
                if (i == 20 && phase == 3)
                begin
                    burst_kind = enrs_pkg::KIND_DEATH_REQ;
                    burst_left = BURST_WORDS;
                    send_event({enrs_pkg::KIND_BIRTH_SENT, 64'd0, 3'b000}, 1'b0, NO_CHECK);
                end
                // receiver holds off while words keep coming
                if (i == 60 && phase == 4)
                    hold_request = 1'b1;
                if (i == 150 && phase == 5)
                    wait_for_reports();
                ev = random_event();
                if (burst_left > 0)
                begin
                    ev.kind = burst_kind;
                    burst_left--;
                end
                send_event(ev, 1'b0, NO_CHECK);
            end
            wait_for_reports();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/enrs_pkg.sv
rtl/edge_node_report_sequencer.sv
verif/tb.sv
